// ===== design/rfes_pkg.sv =====
// Package for the RTC field to epoch seconds unit.
// Holds beat types, sequencer codes, calendar constants and tables.
// No dependencies.
package rfes_pkg;

  // Calendar constants.
  localparam logic [11:0] EPOCH_YEAR    = 12'd1970;
  localparam logic [11:0] BASE_YEAR     = 12'd2000;
  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [16:0] SECS_PER_MIN  = 17'd60;
  localparam logic [16:0] SECS_PER_SEC  = 17'd1;

  // Residues of the epoch year, used to seed the leap year counters.
  localparam logic [1:0] EPOCH_MOD4   = 2'd2;
  localparam logic [6:0] EPOCH_MOD100 = 7'd70;
  localparam logic [8:0] EPOCH_MOD400 = 9'd370;

  // Configuration register indexes.
  localparam logic CFG_BCD_MODE  = 1'b0;
  localparam logic CFG_TWELVE_HR = 1'b1;

  // Input beat: raw clock bytes.
  typedef struct packed {
    logic [7:0] raw_seconds;
    logic [7:0] raw_minutes;
    logic [7:0] raw_hours;
    logic [7:0] raw_monthday;
    logic [7:0] raw_month;
    logic [7:0] raw_year;
  } rfes_in_t;

  // Result beat.
  typedef struct packed {
    logic [31:0] epoch_seconds;
    logic        field_error;
  } rfes_out_t;

  // Decoded fields with the range checks that need no leap year.
  typedef struct packed {
    logic [7:0] sec;
    logic [7:0] min;
    logic [7:0] hr;
    logic [7:0] day;
    logic [3:0] mon_idx;
    logic       mon_ok;
    logic [7:0] yr;
    logic       err;
  } rfes_dec_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_YEARS,
    ST_DAY,
    ST_MUL_DAY,
    ST_MUL_HR,
    ST_MUL_MIN,
    ST_MUL_SEC,
    ST_LAST,
    ST_OUT
  } rfes_state_t;

  // Operations of the shared multiply and add unit.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_YEAR,
    OP_MONTH,
    OP_DAY,
    OP_MUL_DAY,
    OP_MUL_HR,
    OP_MUL_MIN,
    OP_MUL_SEC,
    OP_LAST
  } rfes_op_t;

  typedef struct packed {
    rfes_op_t op;
  } rfes_ctrl_t;

  typedef struct packed {
    logic year_done;
  } rfes_stat_t;

  // Decode one byte, BCD or binary.
  function automatic logic [7:0] bcd_decode(input logic [7:0] b, input logic bcd);
    logic [7:0] hi;
    hi = {4'b0000, b[7:4]};
    if (bcd) begin
      return 8'((hi << 3) + (hi << 1) + {4'b0000, b[3:0]});
    end
    return b;
  endfunction

  // Days before the first of each month in a common year.
  function automatic logic [8:0] days_before_month(input logic [3:0] idx);
    case (idx)
      4'd0:    return 9'd0;
      4'd1:    return 9'd31;
      4'd2:    return 9'd59;
      4'd3:    return 9'd90;
      4'd4:    return 9'd120;
      4'd5:    return 9'd151;
      4'd6:    return 9'd181;
      4'd7:    return 9'd212;
      4'd8:    return 9'd243;
      4'd9:    return 9'd273;
      4'd10:   return 9'd304;
      4'd11:   return 9'd334;
      default: return 9'd0;
    endcase
  endfunction

  // Length of each month in a common year.
  function automatic logic [4:0] month_length(input logic [3:0] idx);
    case (idx)
      4'd1:              return 5'd28;
      4'd3, 4'd5, 4'd8,
      4'd10:             return 5'd30;
      default:           return 5'd31;
    endcase
  endfunction

endpackage

// ===== design/rfes_decode.sv =====
// Field decoder: BCD or binary bytes, 12-hour conversion, static range checks.
// Depends on rfes_pkg.
module rfes_decode import rfes_pkg::*; (
  input  rfes_in_t  fields,
  input  logic      bcd_mode,
  input  logic      twelve_hour_mode,
  output rfes_dec_t dec
);

  logic [7:0] hr_raw;
  logic [7:0] hr12;
  logic [7:0] mon;
  logic       hr12_bad;

  always_comb begin
    dec.sec = bcd_decode(fields.raw_seconds, bcd_mode);
    dec.min = bcd_decode(fields.raw_minutes, bcd_mode);
    dec.day = bcd_decode(fields.raw_monthday, bcd_mode);
    dec.yr  = bcd_decode(fields.raw_year, bcd_mode);
    mon     = bcd_decode(fields.raw_month, bcd_mode);

    // In 12-hour mode the PM flag is stripped before decoding.
    hr_raw   = bcd_decode({1'b0, fields.raw_hours[6:0]}, bcd_mode);
    hr12_bad = (hr_raw < 8'd1) || (hr_raw > 8'd12);
    hr12     = (hr_raw == 8'd12) ? 8'd0 : hr_raw;
    if (fields.raw_hours[7]) begin
      hr12 = hr12 + 8'd12;
    end

    if (twelve_hour_mode) begin
      dec.hr = hr12;
    end else begin
      dec.hr = bcd_decode(fields.raw_hours, bcd_mode);
    end

    dec.mon_ok  = (mon >= 8'd1) && (mon <= 8'd12);
    dec.mon_idx = 4'(mon - 8'd1);

    // The check of the day against the month length waits for the leap flag.
    dec.err = (twelve_hour_mode && hr12_bad) || (dec.sec > 8'd59) || (dec.min > 8'd59) ||
              (dec.hr > 8'd23) || (dec.yr > 8'd99) || !dec.mon_ok || (dec.day < 8'd1);
  end

endmodule

// ===== design/rfes_datapath.sv =====
// Datapath: year counters with leap tracking, one shared adder, one constant
// multiplier with a product register. Depends on rfes_pkg.
module rfes_datapath import rfes_pkg::*; (
  input  logic       clk,
  input  rfes_dec_t  dec,
  input  rfes_ctrl_t ctrl,
  output rfes_stat_t stat,
  output rfes_out_t  result
);

  rfes_dec_t   fld;
  logic [11:0] full_year;
  logic [11:0] year;
  logic [1:0]  y4;
  logic [6:0]  y100;
  logic [8:0]  y400;
  logic [31:0] acc;
  logic [31:0] prod;
  logic        err;

  logic        leap;
  logic [8:0]  month_add;
  logic [4:0]  mlen;
  logic [8:0]  day_m1;
  logic [31:0] add_a;
  logic [31:0] add_b;
  logic [31:0] sum;
  logic [31:0] mul_a;
  logic [16:0] mul_b;
  logic [48:0] mul_p;

  // Leap flag of the year counter.
  assign leap = (y4 == 2'd0) && ((y100 != 7'd0) || (y400 == 9'd0));

  assign stat.year_done = (year == full_year);

  // Month offset and month length, valid once the counter reaches the target year.
  always_comb begin
    month_add = 9'd0;
    mlen      = 5'd31;
    if (fld.mon_ok) begin
      month_add = days_before_month(fld.mon_idx);
      if ((fld.mon_idx > 4'd1) && leap) begin
        month_add = month_add + 9'd1;
      end
      mlen = month_length(fld.mon_idx);
      if ((fld.mon_idx == 4'd1) && leap) begin
        mlen = 5'd29;
      end
    end
  end

  // Day of month minus one, negative for day zero.
  assign day_m1 = {1'b0, fld.day} - 9'd1;

  // Shared adder operand selection.
  always_comb begin
    add_a = acc;
    add_b = 32'd0;
    case (ctrl.op)
      OP_YEAR:    add_b = leap ? 32'd366 : 32'd365;
      OP_MONTH:   add_b = {23'd0, month_add};
      OP_DAY:     add_b = {{23{day_m1[8]}}, day_m1};
      OP_MUL_HR:  begin
        add_a = 32'd0;
        add_b = prod;
      end
      OP_MUL_MIN,
      OP_MUL_SEC,
      OP_LAST:    add_b = prod;
      default:    add_b = 32'd0;
    endcase
  end

  assign sum = add_a + add_b;

  // Constant multiplier operand selection.
  always_comb begin
    mul_a = 32'd0;
    mul_b = SECS_PER_SEC;
    case (ctrl.op)
      OP_MUL_DAY: begin
        mul_a = acc;
        mul_b = SECS_PER_DAY;
      end
      OP_MUL_HR:  begin
        mul_a = {24'd0, fld.hr};
        mul_b = SECS_PER_HOUR;
      end
      OP_MUL_MIN: begin
        mul_a = {24'd0, fld.min};
        mul_b = SECS_PER_MIN;
      end
      OP_MUL_SEC: begin
        mul_a = {24'd0, fld.sec};
        mul_b = SECS_PER_SEC;
      end
      default:    mul_a = 32'd0;
    endcase
  end

  assign mul_p = {17'd0, mul_a} * {32'd0, mul_b};

  // Work registers load at accept, prod before first use; none needs reset.
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_LOAD: begin
        fld       <= dec;
        err       <= dec.err;
        full_year <= BASE_YEAR + {4'd0, dec.yr};
        year      <= EPOCH_YEAR;
        y4        <= EPOCH_MOD4;
        y100      <= EPOCH_MOD100;
        y400      <= EPOCH_MOD400;
        acc       <= 32'd0;
      end
      OP_YEAR: begin
        acc  <= sum;
        year <= year + 12'd1;
        y4   <= y4 + 2'd1;
        y100 <= (y100 == 7'd99) ? 7'd0 : y100 + 7'd1;
        y400 <= (y400 == 9'd399) ? 9'd0 : y400 + 9'd1;
      end
      OP_MONTH: begin
        acc <= sum;
        if ({3'd0, fld.day} > {6'd0, mlen}) begin
          err <= 1'b1;
        end
      end
      OP_DAY: begin
        acc <= sum;
      end
      OP_MUL_DAY: begin
        prod <= mul_p[31:0];
      end
      OP_MUL_HR, OP_MUL_MIN, OP_MUL_SEC: begin
        acc  <= sum;
        prod <= mul_p[31:0];
      end
      OP_LAST: begin
        acc <= sum;
      end
      default: begin
      end
    endcase
  end

  assign result.epoch_seconds = acc;
  assign result.field_error   = err;

endmodule

// ===== design/rfes_ctrl.sv =====
// Sequencer: walks the year loop and the scaling steps of the shared unit.
// Depends on rfes_pkg.
module rfes_ctrl import rfes_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  rfes_stat_t stat,
  output rfes_ctrl_t ctrl,
  output logic       busy,
  output logic       done
);

  rfes_state_t state;
  rfes_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and the operation of the shared unit.
  always_comb begin
    state_next = state;
    ctrl.op    = OP_NONE;
    busy       = 1'b1;
    done       = 1'b0;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctrl.op    = OP_LOAD;
          state_next = ST_YEARS;
        end
      end
      ST_YEARS: begin
        // The month step runs once the counter sits on the target year.
        if (stat.year_done) begin
          ctrl.op    = OP_MONTH;
          state_next = ST_DAY;
        end else begin
          ctrl.op = OP_YEAR;
        end
      end
      ST_DAY: begin
        ctrl.op    = OP_DAY;
        state_next = ST_MUL_DAY;
      end
      ST_MUL_DAY: begin
        ctrl.op    = OP_MUL_DAY;
        state_next = ST_MUL_HR;
      end
      ST_MUL_HR: begin
        ctrl.op    = OP_MUL_HR;
        state_next = ST_MUL_MIN;
      end
      ST_MUL_MIN: begin
        ctrl.op    = OP_MUL_MIN;
        state_next = ST_MUL_SEC;
      end
      ST_MUL_SEC: begin
        ctrl.op    = OP_MUL_SEC;
        state_next = ST_LAST;
      end
      ST_LAST: begin
        ctrl.op    = OP_LAST;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        done       = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/rtc_fields_to_epoch_seconds_unit.sv =====
// Top level of the RTC field to epoch seconds unit.
// Instantiates rfes_decode, rfes_ctrl and rfes_datapath; depends on rfes_pkg.
//
// Usage:
//   A command beat is taken on fields at a rising edge with start high and
//   busy low. The unit then stays busy and, when finished, shows one result
//   beat on result with done high for exactly one cycle; the receiver must
//   take it then, as there is no back pressure.
//   The year loop adds one year per cycle from 1970 to the year before
//   2000 plus the decoded year byte, and so sets how long a command takes;
//   the scaling steps after it use one constant multiplier and the same
//   adder. The result beat is taken at the edge that ends done, and the
//   next command is taken once the unit is back in idle, so a new command
//   is not taken while one is in flight.
//   Configuration: cfg_write with cfg_index and cfg_data writes bcd_mode
//   (index 0) or twelve_hour_mode (index 1); the user must write it only
//   while the unit is idle, as the block itself does not enforce this.
//   Reset: rst is synchronous; it returns the sequencer to idle and sets
//   bcd_mode to 1 and twelve_hour_mode to 0.
module rtc_fields_to_epoch_seconds_unit import rfes_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  rfes_in_t  fields,
  output logic      done,
  output rfes_out_t result,
  input  logic      cfg_write,
  input  logic      cfg_index,
  input  logic      cfg_data
);

  logic       bcd_mode;
  logic       twelve_hour_mode;
  rfes_dec_t  dec;
  rfes_ctrl_t ctrl;
  rfes_stat_t stat;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      bcd_mode         <= 1'b1;
      twelve_hour_mode <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_BCD_MODE:  bcd_mode         <= cfg_data;
        CFG_TWELVE_HR: twelve_hour_mode <= cfg_data;
        default:       bcd_mode         <= bcd_mode;
      endcase
    end
  end

  rfes_decode u_decode (
    .fields           (fields),
    .bcd_mode         (bcd_mode),
    .twelve_hour_mode (twelve_hour_mode),
    .dec              (dec)
  );

  rfes_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (busy),
    .done  (done)
  );

  rfes_datapath u_datapath (
    .clk    (clk),
    .dec    (dec),
    .ctrl   (ctrl),
    .stat   (stat),
    .result (result)
  );

endmodule

// ===== design/rfes_checker.sv =====
// Port checker for the RTC field to epoch seconds unit, with its bind.
// Sees only the top level's handshake ports; no package needed.
module rfes_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // A result beat only appears while a command is in flight.
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result beat outside a busy period");

  // An accepted command makes the unit busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("command accepted but unit not busy");

  // The result strobe lasts one cycle.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");

  // Busy ends only right after the result beat.
  a_busy_end: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> $past(done))
    else $error("busy dropped without a result beat");

endmodule

bind rtc_fields_to_epoch_seconds_unit rfes_checker u_rfes_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

// ===== tb/tb_rtc_fields_to_epoch_seconds_unit.sv =====
// Testbench for rtc_fields_to_epoch_seconds_unit: directed calendar corners, then random
// clock readings under every mode setting, each checked against an in-bench predictor.
// Depends on rfes_pkg and the unit's RTL; stands alone otherwise.
module tb_rtc_fields_to_epoch_seconds_unit;
  import rfes_pkg::*;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  rfes_in_t  fields = '0;
  logic      done;
  rfes_out_t result;
  logic      cfg_write = 1'b0;
  logic      cfg_index = CFG_BCD_MODE;
  logic      cfg_data = 1'b0;

  // Mode registers as the unit holds them, starting from their reset values.
  logic bcd_cfg = 1'b1;
  logic twelve_cfg = 1'b0;

  // Epoch values still owed by the unit, oldest first.
  rfes_out_t   epoch_queue[$];
  rfes_out_t   want;
  int unsigned mismatch_count = 0;

  int unsigned month_len[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  int unsigned days_ahead[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  rtc_fields_to_epoch_seconds_unit i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .fields(fields),
    .done(done),
    .result(result),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Gregorian leap year rule.
  function automatic logic leap_year(int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  // Value of one clock byte; BCD digits are not checked, so 0xFF reads as 165.
  function automatic int unsigned clock_byte(logic [7:0] b, logic bcd);
    if (bcd) begin
      return int'(b[7:4]) * 10 + int'(b[3:0]);
    end
    return int'(b);
  endfunction

  // Encoding of a value 0..99 in the clock's byte format.
  function automatic logic [7:0] to_clock_byte(int unsigned v, logic bcd);
    if (bcd) begin
      return 8'((v / 10) * 16 + v % 10);
    end
    return 8'(v);
  endfunction

  // Seconds since 1970 for one reading, wrapping at 32 bits, plus the range flag.
  function automatic rfes_out_t expected_epoch(rfes_in_t f, logic bcd, logic twelve);
    int unsigned secs, mins, hrs, day, mon, yr, full_yr, mlen;
    logic [31:0] t;
    logic        err;
    rfes_out_t   r;
    secs = clock_byte(f.raw_seconds, bcd);
    mins = clock_byte(f.raw_minutes, bcd);
    day  = clock_byte(f.raw_monthday, bcd);
    mon  = clock_byte(f.raw_month, bcd);
    yr   = clock_byte(f.raw_year, bcd);
    err  = 1'b0;
    full_yr = 2000 + yr;
    // The PM bit comes off before decoding; 12 maps to 0 before PM adds 12.
    if (twelve) begin
      hrs = clock_byte({1'b0, f.raw_hours[6:0]}, bcd);
      if (hrs < 1 || hrs > 12) err = 1'b1;
      if (hrs == 12) hrs = 0;
      if (f.raw_hours[7]) hrs += 12;
    end else begin
      hrs = clock_byte(f.raw_hours, bcd);
    end
    if (secs > 59 || mins > 59 || hrs > 23 || yr > 99) err = 1'b1;
    if (mon < 1 || mon > 12) begin
      err  = 1'b1;
      mlen = 31;
    end else begin
      mlen = month_len[mon - 1];
      if (mon == 2 && leap_year(full_yr)) mlen = 29;
    end
    if (day < 1 || day > mlen) err = 1'b1;
    // Day zero wraps to minus one day; an invalid month adds nothing.
    t = secs + 60 * mins + 3600 * hrs + 86400 * (day - 1);
    if (mon >= 1 && mon <= 12) begin
      t += 86400 * days_ahead[mon - 1];
      if (mon > 2 && leap_year(full_yr)) t += 86400;
    end
    for (int unsigned y = 1970; y < full_yr; y++) begin
      t += 365 * 86400;
      if (leap_year(y)) t += 86400;
    end
    r.epoch_seconds = t;
    r.field_error   = err;
    return r;
  endfunction

  function automatic rfes_in_t raw_item(logic [7:0] s, logic [7:0] m, logic [7:0] h,
                                        logic [7:0] d, logic [7:0] mo, logic [7:0] y);
    rfes_in_t f;
    f = {s, m, h, d, mo, y};
    return f;
  endfunction

  // A valid calendar reading in the current byte format.
  function automatic rfes_in_t random_date(logic bcd, logic twelve);
    int unsigned yr, mon, mlen, hrs, h12;
    logic [7:0]  hb;
    rfes_in_t    f;
    yr  = $urandom_range(0, 99);
    mon = $urandom_range(1, 12);
    mlen = month_len[mon - 1];
    if (mon == 2 && leap_year(2000 + yr)) mlen = 29;
    hrs = $urandom_range(0, 23);
    f.raw_seconds  = to_clock_byte($urandom_range(0, 59), bcd);
    f.raw_minutes  = to_clock_byte($urandom_range(0, 59), bcd);
    f.raw_monthday = to_clock_byte($urandom_range(1, mlen), bcd);
    f.raw_month    = to_clock_byte(mon, bcd);
    f.raw_year     = to_clock_byte(yr, bcd);
    if (twelve) begin
      h12 = (hrs % 12 == 0) ? 12 : hrs % 12;
      hb  = to_clock_byte(h12, bcd);
      f.raw_hours = {(hrs >= 12) ? 1'b1 : 1'b0, hb[6:0]};
    end else begin
      f.raw_hours = to_clock_byte(hrs, bcd);
    end
    return f;
  endfunction

  // Mostly valid dates, some with one corrupted byte, the rest raw noise.
  function automatic rfes_in_t random_reading();
    rfes_in_t    f;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 85) begin
      f = random_date(bcd_cfg, twelve_cfg);
      if (pick >= 70) f[8 * $urandom_range(0, 5) +: 8] = 8'($urandom);
    end else begin
      f = rfes_in_t'({32'($urandom), 16'($urandom)});
    end
    return f;
  endfunction

  // Offer one beat and hold it until the unit takes it; start stays high on return.
  task automatic send_fields(input rfes_in_t f);
    logic ready;
    start  <= 1'b1;
    fields <= f;
    do begin
      @(negedge clk);
      ready = !busy;
      @(posedge clk);
    end while (!ready);
    epoch_queue.push_back(expected_epoch(f, bcd_cfg, twelve_cfg));
  endtask

  task automatic hold_off(input int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Wait until every result is in and the unit is idle; returns at a rising edge.
  task automatic wait_idle();
    logic quiet;
    start <= 1'b0;
    do begin
      @(negedge clk);
      quiet = !busy;
      @(posedge clk);
    end while (!quiet || epoch_queue.size() != 0);
  endtask

  task automatic write_mode(input logic idx, input logic value);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_BCD_MODE) begin
      bcd_cfg = value;
    end else begin
      twelve_cfg = value;
    end
  endtask

  // Reset modes: BCD bytes, 24-hour clock.
  task automatic test_bcd_calendar();
    send_fields(raw_item(8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00));
    send_fields(raw_item(8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99));
    send_fields(raw_item(8'h00, 8'h00, 8'h00, 8'h29, 8'h02, 8'h24));
    send_fields(raw_item(8'h00, 8'h00, 8'h00, 8'h29, 8'h02, 8'h23));
    send_fields(raw_item(8'h00, 8'h00, 8'h00, 8'h01, 8'h03, 8'h00));
    // Day zero, month zero, month thirteen.
    send_fields(raw_item(8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00));
    send_fields(raw_item(8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00));
    send_fields(raw_item(8'h00, 8'h00, 8'h00, 8'h01, 8'h13, 8'h00));
    // Every field but the month one past its range, then nibbles above nine.
    send_fields(raw_item(8'h60, 8'h60, 8'h24, 8'h32, 8'h12, 8'hA0));
    send_fields(raw_item(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    send_fields(raw_item(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
  endtask

  // Binary bytes: century leap rules and the 32-bit wrap.
  task automatic test_binary_calendar();
    write_mode(CFG_BCD_MODE, 1'b0);
    send_fields(raw_item(8'd59, 8'd59, 8'd23, 8'd31, 8'd12, 8'd99));
    send_fields(raw_item(8'd0, 8'd0, 8'd0, 8'd29, 8'd2, 8'd0));
    send_fields(raw_item(8'd0, 8'd0, 8'd0, 8'd29, 8'd2, 8'd100));
    send_fields(raw_item(8'd0, 8'd0, 8'd0, 8'd1, 8'd3, 8'd100));
    send_fields(raw_item(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
  endtask

  // Twelve-hour hours in binary, then in BCD with the PM bit on top.
  task automatic test_twelve_hour();
    write_mode(CFG_TWELVE_HR, 1'b1);
    send_fields(raw_item(8'd0, 8'd0, 8'h0C, 8'd1, 8'd1, 8'd0));
    send_fields(raw_item(8'd0, 8'd0, 8'h8C, 8'd1, 8'd1, 8'd0));
    send_fields(raw_item(8'd0, 8'd0, 8'h81, 8'd1, 8'd1, 8'd0));
    send_fields(raw_item(8'd0, 8'd0, 8'h00, 8'd1, 8'd1, 8'd0));
    send_fields(raw_item(8'd0, 8'd0, 8'h8D, 8'd1, 8'd1, 8'd0));
    write_mode(CFG_BCD_MODE, 1'b1);
    send_fields(raw_item(8'h30, 8'h45, 8'h12, 8'h15, 8'h06, 8'h50));
    send_fields(raw_item(8'h30, 8'h45, 8'h92, 8'h15, 8'h06, 8'h50));
    send_fields(raw_item(8'h59, 8'h59, 8'h91, 8'h31, 8'h12, 8'h99));
    send_fields(raw_item(8'h00, 8'h00, 8'hFF, 8'h01, 8'h01, 8'h00));
  endtask

  // Random readings in bursts with gaps, short and long, between them.
  task automatic test_random_mix(input int unsigned count);
    int unsigned burst;
    burst = 0;
    for (int unsigned i = 0; i < count; i++) begin
      if (burst == 0) begin
        if ($urandom_range(0, 9) < 7) begin
          hold_off($urandom_range(1, 10));
        end else begin
          hold_off($urandom_range(11, 320));
        end
        burst = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 40 : 8);
      end
      send_fields(random_reading());
      burst--;
    end
  endtask

  // Compare each result beat with the oldest prediction.
  always @(negedge clk) begin
    if (!rst && done) begin
      if (epoch_queue.size() == 0) begin
        $error("result beat with no prediction pending: epoch_seconds %0d", result.epoch_seconds);
        mismatch_count++;
      end else begin
        want = epoch_queue.pop_front();
        if (result.epoch_seconds !== want.epoch_seconds) begin
          $error("epoch_seconds: expected %0d, actual %0d",
                 want.epoch_seconds, result.epoch_seconds);
          mismatch_count++;
        end
        if (result.field_error !== want.field_error) begin
          $error("field_error: expected %0b, actual %0b", want.field_error, result.field_error);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_bcd_calendar();
    test_binary_calendar();
    test_twelve_hour();
    test_random_mix(240);
    write_mode(CFG_TWELVE_HR, 1'b0);
    test_random_mix(240);
    write_mode(CFG_BCD_MODE, 1'b0);
    test_random_mix(235);
    write_mode(CFG_TWELVE_HR, 1'b1);
    test_random_mix(235);
    start <= 1'b0;
    while (epoch_queue.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #20000000;
    $error("timeout with %0d results outstanding", epoch_queue.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
